/* hdl/tsnw_pkg.sv */
// Shared constants, types and the radix-16 restoring divide step for the
// texture store / nearest-texel sampler. No dependencies.
`default_nettype none
package tsnw_pkg;

  localparam int unsigned MaxSide    = 256;
  localparam int unsigned MaxTexels  = 65536;
  localparam int unsigned FracBits   = 16;

  localparam int unsigned ChanW      = FracBits + 1;
  localparam int unsigned TexelW     = 3 * ChanW;
  localparam int unsigned AddrW      = $clog2(MaxTexels);
  localparam int unsigned SideW      = $clog2(MaxSide) + 1;
  localparam int unsigned PosW       = $clog2(MaxSide);
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CoordW     = 32;
  localparam int unsigned ScaledW    = CoordW + SideW;
  localparam int unsigned MagW       = ScaledW - 1 - FracBits;
  localparam int unsigned DigitBits  = 4;
  localparam int unsigned NormSteps  = FracBits / DigitBits;
  localparam int unsigned WrapSteps  = MagW / DigitBits;
  localparam int unsigned NormCntW   = $clog2(NormSteps);
  localparam int unsigned WrapCntW   = $clog2(WrapSteps);

  localparam int unsigned InDataW    = 3 * ByteW + 2 * CoordW;
  localparam int unsigned OutDataW   = ((TexelW + 7) / 8) * 8;

  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = SideW;

  localparam logic [CfgIdxW-1:0] CfgTexWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgTexHeight = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgMaxValue  = CfgIdxW'(2);

  localparam logic CmdLoad   = 1'b0;
  localparam logic CmdSample = 1'b1;

  localparam logic [ChanW-1:0] ChanOne = ChanW'(1) << FracBits;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_DIV,
    ST_SMP_MUL,
    ST_SMP_WRAP,
    ST_SMP_MOD,
    ST_SMP_ADDR,
    ST_SMP_READ,
    ST_SMP_OUT
  } tsnw_state_e;

  typedef struct packed {
    logic [DigitBits-1:0] quo;
    logic [SideW-1:0]     rem;
  } div_step_t;

  // Four restoring steps; rem must be below dvs on entry.
  function automatic div_step_t div_step(logic [SideW-1:0] rem,
                                         logic [DigitBits-1:0] bits,
                                         logic [SideW-1:0] dvs);
    div_step_t        r;
    logic [SideW:0]   t;
    logic [SideW-1:0] cur;
    cur = rem;
    r.quo = '0;
    for (int i = DigitBits - 1; i >= 0; i--) begin
      t = {cur, bits[i]};
      if (t >= {1'b0, dvs}) begin
        t = t - {1'b0, dvs};
        r.quo[i] = 1'b1;
      end
      cur = t[SideW-1:0];
    end
    r.rem = cur;
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/tsnw_norm.sv */
// Channel normalizer: (raw * 2^FracBits + m/2) / m saturated at 1.0,
// three channels in parallel, four quotient bits per cycle. Uses tsnw_pkg.
`default_nettype none
module tsnw_norm import tsnw_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [ByteW-1:0]  max_i,
  input  wire logic [ByteW-1:0]  red_i,
  input  wire logic [ByteW-1:0]  green_i,
  input  wire logic [ByteW-1:0]  blue_i,
  output logic                   done_o,
  output logic [TexelW-1:0]      texel_o
);

  logic                busy_q, done_q;
  logic [NormCntW-1:0] cnt_q;
  logic [SideW-1:0]    dvs_q;
  logic [FracBits-1:0] low_q;
  logic [SideW-1:0]    rem_q [3];
  logic [FracBits-1:0] quo_q [3];
  logic                sat_q [3];
  logic [ByteW-1:0]    m_eff;
  logic [ByteW-1:0]    raw [3];
  div_step_t           stp [3];
  logic [ChanW-1:0]    chan [3];

  assign m_eff  = (max_i == '0) ? ByteW'(1) : max_i;
  assign raw[0] = red_i;
  assign raw[1] = green_i;
  assign raw[2] = blue_i;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      stp[c]  = div_step(rem_q[c], low_q[FracBits-1 -: DigitBits], dvs_q);
      chan[c] = sat_q[c] ? ChanOne : {1'b0, quo_q[c]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + NormCntW'(1);
        if (cnt_q == NormCntW'(NormSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q <= {1'b0, m_eff};
      low_q <= FracBits'(m_eff >> 1);
      for (int c = 0; c < 3; c++) begin
        sat_q[c] <= raw[c] >= m_eff;
        rem_q[c] <= (raw[c] >= m_eff) ? '0 : {1'b0, raw[c]};
        quo_q[c] <= '0;
      end
    end else if (busy_q) begin
      low_q <= low_q << DigitBits;
      for (int c = 0; c < 3; c++) begin
        rem_q[c] <= stp[c].rem;
        quo_q[c] <= {quo_q[c][FracBits-DigitBits-1:0], stp[c].quo};
      end
    end
  end

  assign done_o  = done_q;
  assign texel_o = {chan[2], chan[1], chan[0]};

endmodule
`default_nettype wire

/* hdl/tsnw_wrap.sv */
// Coordinate wrap: |scaled| >> FracBits modulo the side, both axes in
// parallel, four bits per cycle, then a sign repair. Uses tsnw_pkg.
`default_nettype none
module tsnw_wrap import tsnw_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic signed [ScaledW-1:0] sx_i,
  input  wire logic signed [ScaledW-1:0] sy_i,
  input  wire logic [SideW-1:0]          w_i,
  input  wire logic [SideW-1:0]          h_i,
  output logic                           done_o,
  output logic [PosW-1:0]                x_o,
  output logic [PosW-1:0]                y_o
);

  logic                busy_q, done_q;
  logic [WrapCntW-1:0] cnt_q;
  logic [MagW-1:0]     mag_q [2];
  logic [SideW-1:0]    rem_q [2];
  logic [SideW-1:0]    dvs_q [2];
  logic                neg_q [2];
  logic [ScaledW-1:0]  absv  [2];
  logic signed [ScaledW-1:0] sv [2];
  div_step_t           stp   [2];
  logic [SideW-1:0]    res   [2];

  assign sv[0] = sx_i;
  assign sv[1] = sy_i;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      absv[a] = sv[a][ScaledW-1] ? ScaledW'(-sv[a]) : ScaledW'(sv[a]);
      stp[a]  = div_step(rem_q[a], mag_q[a][MagW-1 -: DigitBits], dvs_q[a]);
      res[a]  = (neg_q[a] && rem_q[a] != '0) ? dvs_q[a] - rem_q[a] : rem_q[a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + WrapCntW'(1);
        if (cnt_q == WrapCntW'(WrapSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q[0] <= w_i;
      dvs_q[1] <= h_i;
      for (int a = 0; a < 2; a++) begin
        mag_q[a] <= absv[a][FracBits +: MagW];
        neg_q[a] <= sv[a][ScaledW-1];
        rem_q[a] <= '0;
      end
    end else if (busy_q) begin
      for (int a = 0; a < 2; a++) begin
        mag_q[a] <= mag_q[a] << DigitBits;
        rem_q[a] <= stp[a].rem;
      end
    end
  end

  assign done_o = done_q;
  assign x_o    = res[0][PosW-1:0];
  assign y_o    = res[1][PosW-1:0];

endmodule
`default_nettype wire

/* hdl/tsnw_texmem.sv */
// Texel store: single-port-write, registered-read synchronous RAM holding
// three 1.FracBits channels per entry. Uses tsnw_pkg.
`default_nettype none
module tsnw_texmem import tsnw_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AddrW-1:0]  waddr_i,
  input  wire logic [TexelW-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [AddrW-1:0]  raddr_i,
  output logic [TexelW-1:0]      rdata_o
);

  logic [TexelW-1:0] mem [MaxTexels];
  logic [TexelW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* hdl/texture_store_nearest_wrap_sampler.sv */
// Texture store with nearest-texel repeat-wrap sampling. A load transaction
// (tuser 0) takes one RGB byte triple in image order, top row first, and
// writes it normalized to 1.16 with the rows flipped; it yields no output.
// A sample transaction (tuser 1) yields one result: the texel at the wrapped
// Q15.16 coordinates with tuser 1, or black with tuser 0 until a full image
// is loaded. Writing width or height restarts the image. One transaction is
// in work at a time: a load is paced by the 4-bit-per-cycle normalizing
// divider; a sample by the 4-bit-per-cycle modulo unit (6 steps) plus
// multiply, address and RAM read stages; a sample before the image is
// complete skips these. A new transaction is taken while a result
// waits in the output register. No clearing pass after reset.
// Uses tsnw_pkg, tsnw_norm, tsnw_wrap, tsnw_texmem.
`default_nettype none
module texture_store_nearest_wrap_sampler import tsnw_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // red_in[7:0], green_in[15:8], blue_in[23:16], s_coord[55:24], t_coord[87:56]
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // cmd
  input  wire logic                s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // red_out[16:0], green_out[33:17], blue_out[50:34], zeros[55:51]
  output logic [OutDataW-1:0]      m_axis_tdata,
  // image_ready
  output logic                     m_axis_tuser
);

  tsnw_state_e state_q, state_d;

  logic [SideW-1:0] tex_w_q, tex_h_q, w_eff, h_eff;
  logic [ByteW-1:0] max_q;
  logic [PosW-1:0]  col_q, row_q;
  logic             loaded_q;

  logic             in_acc, is_load, norm_start, norm_done;
  logic             wrap_start, wrap_done, mem_we, mem_re, out_load;
  logic [TexelW-1:0] norm_texel, rd_texel;
  logic [PosW-1:0]  wrap_x, wrap_y;

  logic signed [CoordW-1:0]  s_q, t_q;
  logic signed [ScaledW-1:0] prod_x_q, prod_y_q, w_ext, h_ext;
  logic [PosW-1:0]  mul_a_q, add_q;
  logic [AddrW-1:0] addr_q;
  logic             res_img_q;

  logic             out_valid_q, out_user_q;
  logic [TexelW-1:0] out_data_q;

  logic [PosW-1:0]  col_eff, row_eff, hrow;
  logic [SideW-1:0] col_nx, row_nx;
  logic             first_tx;

  assign w_eff = (tex_w_q == '0) ? SideW'(1) :
                 (tex_w_q > SideW'(MaxSide)) ? SideW'(MaxSide) : tex_w_q;
  assign h_eff = (tex_h_q == '0) ? SideW'(1) :
                 (tex_h_q > SideW'(MaxSide)) ? SideW'(MaxSide) : tex_h_q;
  assign w_ext = ScaledW'({1'b0, w_eff});
  assign h_ext = ScaledW'({1'b0, h_eff});

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign is_load = s_axis_tuser == CmdLoad;

  // load position bookkeeping
  assign col_eff  = ({1'b0, col_q} >= w_eff) ? '0 : col_q;
  assign row_eff  = ({1'b0, row_q} >= h_eff) ? '0 : row_q;
  assign first_tx = (col_eff == '0) && (row_eff == '0);
  assign hrow     = PosW'(h_eff - SideW'(1) - {1'b0, row_eff});
  assign col_nx   = {1'b0, col_eff} + SideW'(1);
  assign row_nx   = {1'b0, row_eff} + SideW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    norm_start    = 1'b0;
    wrap_start    = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (is_load) begin
            norm_start = 1'b1;
            state_d    = ST_LOAD_DIV;
          end else if (loaded_q) begin
            state_d = ST_SMP_MUL;
          end else begin
            state_d = ST_SMP_OUT;
          end
        end
      end
      ST_LOAD_DIV: begin
        if (norm_done) begin
          mem_we  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SMP_MUL:  state_d = ST_SMP_WRAP;
      ST_SMP_WRAP: begin
        wrap_start = 1'b1;
        state_d    = ST_SMP_MOD;
      end
      ST_SMP_MOD: begin
        if (wrap_done) begin
          state_d = ST_SMP_ADDR;
        end
      end
      ST_SMP_ADDR: state_d = ST_SMP_READ;
      ST_SMP_READ: begin
        mem_re  = 1'b1;
        state_d = ST_SMP_OUT;
      end
      ST_SMP_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // configuration and load counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_w_q  <= SideW'(1);
      tex_h_q  <= SideW'(1);
      max_q    <= ByteW'(255);
      col_q    <= '0;
      row_q    <= '0;
      loaded_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgTexWidth: begin
            tex_w_q  <= cfg_data_i;
            col_q    <= '0;
            row_q    <= '0;
            loaded_q <= 1'b0;
          end
          CfgTexHeight: begin
            tex_h_q  <= cfg_data_i;
            col_q    <= '0;
            row_q    <= '0;
            loaded_q <= 1'b0;
          end
          CfgMaxValue: max_q <= cfg_data_i[ByteW-1:0];
          default: ;
        endcase
      end else if (in_acc && is_load) begin
        if (col_nx >= w_eff) begin
          col_q <= '0;
          if (row_nx >= h_eff) begin
            row_q    <= '0;
            loaded_q <= 1'b1;
          end else begin
            row_q    <= row_nx[PosW-1:0];
            loaded_q <= first_tx ? 1'b0 : loaded_q;
          end
        end else begin
          col_q    <= col_nx[PosW-1:0];
          row_q    <= row_eff;
          loaded_q <= first_tx ? 1'b0 : loaded_q;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s_q       <= s_axis_tdata[3*ByteW +: CoordW];
      t_q       <= s_axis_tdata[3*ByteW+CoordW +: CoordW];
      res_img_q <= loaded_q;
      if (is_load) begin
        mul_a_q <= hrow;
        add_q   <= col_eff;
      end
    end
    if (state_q == ST_SMP_MUL) begin
      prod_x_q <= ScaledW'(s_q) * w_ext;
      prod_y_q <= ScaledW'(t_q) * h_ext;
    end
    if (state_q == ST_SMP_MOD && wrap_done) begin
      mul_a_q <= wrap_y;
      add_q   <= wrap_x;
    end
    if (state_q == ST_LOAD_DIV || state_q == ST_SMP_ADDR) begin
      addr_q <= AddrW'(mul_a_q * w_eff + SideW'(add_q));
    end
    if (out_load) begin
      out_data_q <= res_img_q ? rd_texel : '0;
      out_user_q <= res_img_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  tsnw_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .max_i   (max_q),
    .red_i   (s_axis_tdata[0 +: ByteW]),
    .green_i (s_axis_tdata[ByteW +: ByteW]),
    .blue_i  (s_axis_tdata[2*ByteW +: ByteW]),
    .done_o  (norm_done),
    .texel_o (norm_texel)
  );

  tsnw_wrap u_wrap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (wrap_start),
    .sx_i    (prod_x_q),
    .sy_i    (prod_y_q),
    .w_i     (w_eff),
    .h_i     (h_eff),
    .done_o  (wrap_done),
    .x_o     (wrap_x),
    .y_o     (wrap_y)
  );

  tsnw_texmem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (addr_q),
    .wdata_i (norm_texel),
    .re_i    (mem_re),
    .raddr_i (addr_q),
    .rdata_o (rd_texel)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_data_q);
  assign m_axis_tuser  = out_user_q;

  a_norm_done_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    norm_done |-> state_q == ST_LOAD_DIV)
    else $error("normalizer finished outside a load");

  a_wrap_done_in_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wrap_done |-> state_q == ST_SMP_MOD)
    else $error("wrap unit finished outside a sample");

  a_mem_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("texel store read and written in one cycle");

  a_size_clears_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == CfgTexWidth || cfg_idx_i == CfgTexHeight)
    |=> !loaded_q)
    else $error("image still marked complete after size change");

  a_black_when_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("non-black result without a complete image");

endmodule
`default_nettype wire

/* tb/sv/texture_store_nearest_wrap_sampler_tb.sv */
// Self-checking testbench for texture_store_nearest_wrap_sampler: texel loads and wrapped
// nearest samples over many sizes, predicted by an in-bench texel store model.
// Depends on tsnw_pkg and the DUT only.
module texture_store_nearest_wrap_sampler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tsnw_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnused = CfgIdxW'(3);
  localparam int unsigned DrainCycles  = 20;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned TotalItems   = 550;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             ready;
  } texel_out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] val;
  } cfg_write_t;

  class texel_scoreboard;
    logic [ChanW-1:0]    red_mem   [MaxTexels];
    logic [ChanW-1:0]    green_mem [MaxTexels];
    logic [ChanW-1:0]    blue_mem  [MaxTexels];
    int unsigned         col;
    int unsigned         row;
    bit                  loaded;
    logic [CfgDataW-1:0] width_reg;
    logic [CfgDataW-1:0] height_reg;
    logic [7:0]          maxval_reg;
    texel_out_t          due_texels[$];
    int unsigned         errors;
    int unsigned         checked;

    function new();
      col        = 0;
      row        = 0;
      loaded     = 1'b0;
      width_reg  = 1;
      height_reg = 1;
      maxval_reg = 8'd255;
      errors     = 0;
      checked    = 0;
    endfunction

    function int unsigned eff_side(logic [CfgDataW-1:0] v);
      if (v == 0) return 1;
      if (v > MaxSide) return MaxSide;
      return v;
    endfunction

    function logic [ChanW-1:0] normalize_byte(logic [7:0] raw);
      longint unsigned m;
      longint unsigned q;
      m = (maxval_reg == 0) ? 1 : maxval_reg;
      q = (longint'(raw) * (64'd1 << FracBits) + m / 2) / m;
      if (q > (64'd1 << FracBits)) q = 64'd1 << FracBits;
      return q[ChanW-1:0];
    endfunction

    function int unsigned wrap_index(logic signed [CoordW-1:0] c, int unsigned size);
      longint scaled;
      longint pos;
      longint r;
      scaled = longint'(c) * longint'(size);
      pos    = scaled / (longint'(1) << FracBits);
      r      = pos % longint'(size);
      if (r < 0) r += longint'(size);
      return int'(r);
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      if (idx == CfgTexWidth || idx == CfgTexHeight) begin
        if (idx == CfgTexWidth) width_reg = val;
        else height_reg = val;
        col    = 0;
        row    = 0;
        loaded = 1'b0;
      end else if (idx == CfgMaxValue) begin
        maxval_reg = val[7:0];
      end
    endfunction

    function void accept_command(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                 logic [CoordW-1:0] s, logic [CoordW-1:0] t);
      int unsigned     w;
      int unsigned     h;
      longint unsigned addr;
      texel_out_t      e;
      w = eff_side(width_reg);
      h = eff_side(height_reg);
      if (cmd == CmdLoad) begin
        if (col >= w) col = 0;
        if (row >= h) row = 0;
        if (col == 0 && row == 0) loaded = 1'b0;
        // rows are stored bottom-up
        addr = longint'(h - 1 - row) * w + col;
        if (addr < MaxTexels) begin
          red_mem[addr]   = normalize_byte(r);
          green_mem[addr] = normalize_byte(g);
          blue_mem[addr]  = normalize_byte(b);
        end
        col++;
        if (col >= w) begin
          col = 0;
          row++;
          if (row >= h) begin
            row    = 0;
            loaded = 1'b1;
          end
        end
      end else begin
        e = '0;
        if (loaded) begin
          addr = longint'(wrap_index(t, h)) * w + wrap_index(s, w);
          if (addr < MaxTexels) begin
            e.red   = red_mem[addr];
            e.green = green_mem[addr];
            e.blue  = blue_mem[addr];
          end
          e.ready = 1'b1;
        end
        due_texels.push_back(e);
      end
    endfunction

    function void check_sample(logic [OutDataW-1:0] data, logic user);
      texel_out_t e;
      texel_out_t got;
      if (due_texels.size() == 0) begin
        $error("result with no sample pending: tdata %h tuser %b", data, user);
        errors++;
        return;
      end
      e         = due_texels.pop_front();
      got.red   = data[ChanW-1:0];
      got.green = data[2*ChanW-1:ChanW];
      got.blue  = data[3*ChanW-1:2*ChanW];
      got.ready = user;
      checked++;
      if (got.red !== e.red) begin
        $error("red_out: expected %0d, got %0d", e.red, got.red);
        errors++;
      end
      if (got.green !== e.green) begin
        $error("green_out: expected %0d, got %0d", e.green, got.green);
        errors++;
      end
      if (got.blue !== e.blue) begin
        $error("blue_out: expected %0d, got %0d", e.blue, got.blue);
        errors++;
      end
      if (got.ready !== e.ready) begin
        $error("image_ready: expected %0d, got %0d", e.ready, got.ready);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  texel_scoreboard sb = new();
  cfg_write_t      cfg_batch[$];
  bit              tx_steady = 1'b0;
  bit              rx_steady = 1'b0;
  int unsigned     n_loads    = 0;
  int unsigned     n_samples  = 0;
  int unsigned     n_settings = 0;

  texture_store_nearest_wrap_sampler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] rand_byte();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  function automatic logic [CoordW-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($urandom_range(0, 32'h80000)) - 32'h40000;
      2: return ((32'($urandom_range(0, 16)) - 32'd8) << FracBits)
                + 32'($urandom_range(0, 2)) - 32'd1;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] rand_side();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CfgDataW'($urandom_range(7, 16));
      default: return CfgDataW'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] rand_maxval();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CfgDataW'(255);
      2: return CfgDataW'(1);
      default: return CfgDataW'($urandom_range(1, 511));
    endcase
  endfunction

  task automatic send_item(input logic cmd, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b, input logic [CoordW-1:0] s,
                           input logic [CoordW-1:0] t);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {t, s, b, g, r};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.accept_command(cmd, r, g, b, s, t);
    if (cmd == CmdLoad) n_loads++;
    else n_samples++;
  endtask

  task automatic load_random();
    send_item(CmdLoad, rand_byte(), rand_byte(), rand_byte(), rand_coord(), rand_coord());
  endtask

  task automatic sample_random();
    send_item(CmdSample, rand_byte(), rand_byte(), rand_byte(), rand_coord(), rand_coord());
  endtask

  task automatic mixed_item();
    if ($urandom_range(0, 9) == 0) load_random();
    else sample_random();
  endtask

  // wait for all outstanding samples, then for a load still in flight
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.due_texels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apply_cfg();
    foreach (cfg_batch[i]) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= cfg_batch[i].idx;
      cfg_data_i <= cfg_batch[i].val;
      @(posedge clk_i);
      sb.write_reg(cfg_batch[i].idx, cfg_batch[i].val);
    end
    cfg_we_i <= 1'b0;
    cfg_batch.delete();
    n_settings++;
  endtask

  task automatic run_phase(input logic [CfgDataW-1:0] w_val, input logic [CfgDataW-1:0] h_val,
                           input logic [CfgDataW-1:0] mv_val);
    int unsigned texels;
    drain_results();
    cfg_batch.push_back('{CfgTexWidth, w_val});
    cfg_batch.push_back('{CfgTexHeight, h_val});
    cfg_batch.push_back('{CfgMaxValue, mv_val});
    apply_cfg();
    tx_steady = ($urandom_range(0, 3) == 0);
    rx_steady = ($urandom_range(0, 3) == 0);
    texels = sb.eff_side(w_val) * sb.eff_side(h_val);
    for (int i = 0; i < texels; i++) begin
      if (texels < 64 && $urandom_range(0, 11) == 0) sample_random();
      load_random();
    end
    repeat ($urandom_range(4, 16)) mixed_item();
    // new normalization only affects later loads; unknown index is a no-op
    if ($urandom_range(0, 2) == 0) begin
      drain_results();
      cfg_batch.push_back('{CfgMaxValue, rand_maxval()});
      if ($urandom_range(0, 1) == 1) cfg_batch.push_back('{CfgUnused, CfgDataW'($urandom)});
      apply_cfg();
      repeat ($urandom_range(3, 8)) mixed_item();
    end
  endtask

  // receiver with random stalls
  initial begin
    int unsigned stall;
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_sample(m_axis_tdata, m_axis_tuser);
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        quiet = 0;
      else
        quiet++;
    end
    $display("texture_store_nearest_wrap_sampler: mismatch");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset sizes are 1x1: black until the single texel is loaded
    send_item(CmdSample, 8'h00, 8'hFF, 8'h00, 32'h0000_0000, 32'h0000_0000);
    send_item(CmdSample, 8'hFF, 8'h00, 8'hFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(CmdLoad, 8'hFF, 8'h00, 8'h80, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(CmdSample, 8'h00, 8'h00, 8'h00, 32'h0000_0000, 32'h0000_0000);
    send_item(CmdSample, 8'h00, 8'h00, 8'h00, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(CmdSample, 8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF, 32'h0000_0001);
    send_item(CmdSample, 8'h00, 8'h00, 8'h00, 32'hFFFF_0000, 32'h0001_0000);
    // reload restarts and completes the 1x1 image at once
    send_item(CmdLoad, 8'h01, 8'hFE, 8'h7F, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(CmdSample, 8'hFF, 8'hFF, 8'hFF, rand_coord(), rand_coord());

    // 3x2 with zero maximum (acts as one), sample while incomplete
    drain_results();
    cfg_batch.push_back('{CfgTexWidth, CfgDataW'(3)});
    cfg_batch.push_back('{CfgTexHeight, CfgDataW'(2)});
    cfg_batch.push_back('{CfgMaxValue, CfgDataW'(0)});
    apply_cfg();
    send_item(CmdLoad, 8'h00, 8'h01, 8'hFF, 32'h0, 32'h0);
    send_item(CmdLoad, 8'h80, 8'h02, 8'h03, 32'h0, 32'h0);
    send_item(CmdSample, 8'h00, 8'h00, 8'h00, 32'h0, 32'h0);
    send_item(CmdLoad, 8'hFF, 8'hFF, 8'hFF, 32'h0, 32'h0);
    send_item(CmdLoad, 8'h07, 8'h08, 8'h09, 32'h0, 32'h0);
    send_item(CmdLoad, 8'h00, 8'h00, 8'h00, 32'h0, 32'h0);
    send_item(CmdLoad, 8'hC8, 8'h64, 8'h32, 32'h0, 32'h0);
    send_item(CmdSample, 8'h00, 8'h00, 8'h00, 32'hFFFF_8000, 32'h0000_0000);
    send_item(CmdSample, 8'h00, 8'h00, 8'h00, 32'h0002_FFFF, 32'h0001_FFFF);
    send_item(CmdSample, 8'h00, 8'h00, 8'h00, 32'h0003_0000, 32'hFFFE_FFFF);
    send_item(CmdSample, 8'h00, 8'h00, 8'h00, 32'h8000_0000, 32'h7FFF_FFFF);

    // widest and tallest images through out-of-range size values
    run_phase(CfgDataW'(511), CfgDataW'(0), CfgDataW'(255));
    run_phase(CfgDataW'(0), CfgDataW'(300), CfgDataW'(1));

    do
      run_phase(rand_side(), rand_side(), rand_maxval());
    while (n_loads + n_samples < TotalItems);

    tx_steady = 1'b0;
    drain_results();
    $display("Covered %0d loads and %0d samples over %0d register updates;",
             n_loads, n_samples, n_settings);
    $display("%0d sampled texels compared, %0d field errors.", sb.checked, sb.errors);
    if (sb.errors == 0)
      $display("texture_store_nearest_wrap_sampler: match");
    else
      $display("texture_store_nearest_wrap_sampler: mismatch");
    $finish;
  end

endmodule
